>>> design/amdfs_pkg.sv
// Shared types and constants of the adjacency matrix depth-first search engine.
package amdfs_pkg;

  localparam int KindW  = 2;
  localparam int LabelW = 16;
  localparam int StartW = 3;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_VINS,
    S_LK_ISSUE,
    S_LK_CMP,
    S_EDGE,
    S_RANGE,
    S_POP,
    S_POP_CHK,
    S_LABEL,
    S_SCAN_ISSUE,
    S_SCAN_EVAL,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    take;
    logic    clr_step;
    logic    vins;
    logic    lk_start;
    logic    lk_issue;
    logic    lk_cmp;
    logic    edge_wr;
    logic    dfs_start;
    logic    pop_issue;
    logic    visit;
    logic    pend_load;
    logic    scan_start;
    logic    scan_issue;
    logic    scan_eval;
    logic    emit;
    status_e emit_status;
    logic    emit_pend;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    logic             clr_done;
    logic [KindW-1:0] kind;
    logic             full;
    logic             start_bad;
    logic             lk_done;
    logic             found;
    logic             sp_zero;
    logic             seen;
    logic             pend_vld;
    logic             scan_done;
    logic             out_free;
  } stat_t;

endpackage

>>> design/amdfs_ctrl.sv
// Controller state machine: sequences insert, lookup and search steps of the datapath.
module amdfs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  amdfs_pkg::stat_t   stat_i,
  output amdfs_pkg::cmd_t    cmd_o
);

  amdfs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amdfs_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      amdfs_pkg::S_CLEAR: begin
        if (stat_i.clr_done) begin
          state_d = amdfs_pkg::S_IDLE;
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      amdfs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i) begin
          state_d = amdfs_pkg::S_DECODE;
        end
      end
      amdfs_pkg::S_DECODE: begin
        unique case (stat_i.kind)
          amdfs_pkg::KIND_VERTEX: state_d = amdfs_pkg::S_VINS;
          amdfs_pkg::KIND_EDGE: begin
            cmd_o.lk_start = 1'b1;
            state_d        = amdfs_pkg::S_LK_ISSUE;
          end
          amdfs_pkg::KIND_SEARCH: begin
            if (stat_i.start_bad) begin
              state_d = amdfs_pkg::S_RANGE;
            end else begin
              cmd_o.dfs_start = 1'b1;
              state_d         = amdfs_pkg::S_POP;
            end
          end
          default: state_d = amdfs_pkg::S_IDLE;
        endcase
      end
      amdfs_pkg::S_VINS: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          if (stat_i.full) begin
            cmd_o.emit_status = amdfs_pkg::ST_FULL;
          end else begin
            cmd_o.emit_status = amdfs_pkg::ST_OK;
            cmd_o.vins        = 1'b1;
          end
          state_d = amdfs_pkg::S_IDLE;
        end
      end
      amdfs_pkg::S_LK_ISSUE: begin
        if (stat_i.lk_done) begin
          state_d = amdfs_pkg::S_EDGE;
        end else begin
          cmd_o.lk_issue = 1'b1;
          state_d        = amdfs_pkg::S_LK_CMP;
        end
      end
      amdfs_pkg::S_LK_CMP: begin
        cmd_o.lk_cmp = 1'b1;
        state_d      = amdfs_pkg::S_LK_ISSUE;
      end
      amdfs_pkg::S_EDGE: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          if (stat_i.found) begin
            cmd_o.emit_status = amdfs_pkg::ST_OK;
            cmd_o.edge_wr     = 1'b1;
          end else begin
            cmd_o.emit_status = amdfs_pkg::ST_NOT_FOUND;
          end
          state_d = amdfs_pkg::S_IDLE;
        end
      end
      amdfs_pkg::S_RANGE: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = amdfs_pkg::ST_RANGE;
          state_d           = amdfs_pkg::S_IDLE;
        end
      end
      amdfs_pkg::S_POP: begin
        if (stat_i.sp_zero) begin
          state_d = amdfs_pkg::S_FINISH;
        end else begin
          cmd_o.pop_issue = 1'b1;
          state_d         = amdfs_pkg::S_POP_CHK;
        end
      end
      amdfs_pkg::S_POP_CHK: begin
        if (stat_i.seen) begin
          state_d = amdfs_pkg::S_POP;
        end else begin
          cmd_o.visit = 1'b1;
          state_d     = amdfs_pkg::S_LABEL;
        end
      end
      amdfs_pkg::S_LABEL: begin
        if (!stat_i.pend_vld || stat_i.out_free) begin
          cmd_o.emit        = stat_i.pend_vld;
          cmd_o.emit_pend   = 1'b1;
          cmd_o.emit_status = amdfs_pkg::ST_OK;
          cmd_o.pend_load   = 1'b1;
          cmd_o.scan_start  = 1'b1;
          state_d           = amdfs_pkg::S_SCAN_ISSUE;
        end
      end
      amdfs_pkg::S_SCAN_ISSUE: begin
        if (stat_i.scan_done) begin
          state_d = amdfs_pkg::S_POP;
        end else begin
          cmd_o.scan_issue = 1'b1;
          state_d          = amdfs_pkg::S_SCAN_EVAL;
        end
      end
      amdfs_pkg::S_SCAN_EVAL: begin
        cmd_o.scan_eval = 1'b1;
        state_d         = amdfs_pkg::S_SCAN_ISSUE;
      end
      amdfs_pkg::S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_pend   = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = amdfs_pkg::ST_OK;
          state_d           = amdfs_pkg::S_IDLE;
        end
      end
      default: state_d = amdfs_pkg::S_IDLE;
    endcase
  end

endmodule

>>> design/amdfs_dp.sv
// Datapath: label table, edge matrix, search stack, visited marks and result register.
module amdfs_dp #(
  parameter int MAX_VERTICES = 8,
  parameter int STACK_DEPTH  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [amdfs_pkg::KindW-1:0]         kind_i,
  input  logic [amdfs_pkg::LabelW-1:0]        vertex_value_i,
  input  logic [amdfs_pkg::LabelW-1:0]        source_value_i,
  input  logic [amdfs_pkg::LabelW-1:0]        dest_value_i,
  input  logic [amdfs_pkg::LabelW-1:0]        edge_distance_i,
  input  logic [amdfs_pkg::StartW-1:0]        start_index_i,
  input  amdfs_pkg::cmd_t                     cmd_i,
  output amdfs_pkg::stat_t                    stat_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [1:0]                          status_o,
  output logic [amdfs_pkg::LabelW-1:0]        visited_label_o,
  output logic                                is_last_o
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int Cells = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(Cells);
  localparam int CLW   = $clog2(Cells + 1);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int CmpW  = (CW > amdfs_pkg::StartW) ? CW : amdfs_pkg::StartW;
  localparam int LW    = amdfs_pkg::LabelW;

  logic [amdfs_pkg::KindW-1:0]  kind_q;
  logic [LW-1:0]                vval_q, src_q, dst_q, dist_q;
  logic [amdfs_pkg::StartW-1:0] start_q;

  logic [CW-1:0]           vcount_q;
  logic [CLW-1:0]          clr_q;
  logic [CW-1:0]           lk_idx_q;
  logic [VW-1:0]           src_slot_q, dst_slot_q;
  logic                    src_hit_q, dst_hit_q;
  logic [SPW-1:0]          sp_q;
  logic [MAX_VERTICES-1:0] visited_q;
  logic [VW-1:0]           v_q;
  logic [CW-1:0]           scan_q;
  logic [LW-1:0]           pend_q;
  logic                    pend_vld_q;

  logic [LW-1:0] label_mem [MAX_VERTICES];
  logic [LW-1:0] label_rd_q;
  logic [LW-1:0] edge_mem [Cells];
  logic [LW-1:0] edge_rd_q;
  logic [VW-1:0] stack_mem [STACK_DEPTH];
  logic [VW-1:0] stk_rd_q;

  logic                out_vld_q;
  amdfs_pkg::status_e  status_q;
  logic [LW-1:0]       label_q;
  logic                last_q;

  logic [VW-1:0]  scan_w;
  logic           push_ok;
  logic           edge_we;
  logic [AW-1:0]  edge_wa, edge_ra;
  logic [LW-1:0]  edge_wd;
  logic           lbl_re;
  logic [VW-1:0]  lbl_ra;
  logic           stk_we;
  logic [SAW-1:0] stk_wa, stk_ra;
  logic [VW-1:0]  stk_wd;

  assign scan_w  = VW'(scan_q - 1'b1);
  assign push_ok = (edge_rd_q != '0) && !visited_q[scan_w] && (sp_q < SPW'(STACK_DEPTH));

  assign edge_we = cmd_i.clr_step | cmd_i.edge_wr;
  assign edge_wa = cmd_i.clr_step ? AW'(clr_q)
                                  : AW'(src_slot_q) * AW'(MAX_VERTICES) + AW'(dst_slot_q);
  assign edge_wd = cmd_i.clr_step ? '0 : dist_q;
  assign edge_ra = AW'(v_q) * AW'(MAX_VERTICES) + AW'(scan_w);

  assign lbl_re = cmd_i.lk_issue | cmd_i.visit;
  assign lbl_ra = cmd_i.visit ? stk_rd_q : VW'(lk_idx_q);

  assign stk_we = cmd_i.dfs_start | (cmd_i.scan_eval & push_ok);
  assign stk_wa = cmd_i.dfs_start ? '0 : SAW'(sp_q);
  assign stk_wd = cmd_i.dfs_start ? VW'(start_q) : scan_w;
  assign stk_ra = SAW'(sp_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
    if (cmd_i.scan_issue) begin
      edge_rd_q <= edge_mem[edge_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vins) begin
      label_mem[VW'(vcount_q)] <= vval_q;
    end
    if (lbl_re) begin
      label_rd_q <= label_mem[lbl_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (cmd_i.pop_issue) begin
      stk_rd_q <= stack_mem[stk_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q  <= kind_i;
      vval_q  <= vertex_value_i;
      src_q   <= source_value_i;
      dst_q   <= dest_value_i;
      dist_q  <= edge_distance_i;
      start_q <= start_index_i;
    end
    if (cmd_i.visit) begin
      v_q <= stk_rd_q;
    end
    if (cmd_i.pend_load) begin
      pend_q <= label_rd_q;
    end
    if (cmd_i.lk_cmp && !src_hit_q && label_rd_q == src_q) begin
      src_slot_q <= VW'(lk_idx_q);
    end
    if (cmd_i.lk_cmp && !dst_hit_q && label_rd_q == dst_q) begin
      dst_slot_q <= VW'(lk_idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= '0;
      clr_q      <= '0;
      lk_idx_q   <= '0;
      src_hit_q  <= 1'b0;
      dst_hit_q  <= 1'b0;
      sp_q       <= '0;
      visited_q  <= '0;
      scan_q     <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.vins) begin
        vcount_q <= vcount_q + 1'b1;
      end
      if (cmd_i.lk_start) begin
        lk_idx_q  <= '0;
        src_hit_q <= 1'b0;
        dst_hit_q <= 1'b0;
      end else if (cmd_i.lk_cmp) begin
        lk_idx_q <= lk_idx_q + 1'b1;
        if (label_rd_q == src_q) begin
          src_hit_q <= 1'b1;
        end
        if (label_rd_q == dst_q) begin
          dst_hit_q <= 1'b1;
        end
      end
      if (cmd_i.dfs_start) begin
        sp_q       <= SPW'(1);
        visited_q  <= '0;
        pend_vld_q <= 1'b0;
      end else begin
        if (cmd_i.pop_issue) begin
          sp_q <= sp_q - 1'b1;
        end else if (cmd_i.scan_eval && push_ok) begin
          sp_q <= sp_q + 1'b1;
        end
        if (cmd_i.visit) begin
          visited_q[stk_rd_q] <= 1'b1;
        end
        if (cmd_i.pend_load) begin
          pend_vld_q <= 1'b1;
        end
      end
      if (cmd_i.scan_start) begin
        scan_q <= vcount_q;
      end else if (cmd_i.scan_eval) begin
        scan_q <= scan_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      label_q  <= cmd_i.emit_pend ? pend_q : '0;
      last_q   <= cmd_i.emit_last;
    end
  end

  always_comb begin
    stat_o           = '0;
    stat_o.clr_done  = (clr_q == CLW'(Cells));
    stat_o.kind      = kind_q;
    stat_o.full      = (vcount_q == CW'(MAX_VERTICES));
    stat_o.start_bad = (CmpW'(start_q) >= CmpW'(vcount_q));
    stat_o.lk_done   = (lk_idx_q == vcount_q);
    stat_o.found     = src_hit_q & dst_hit_q;
    stat_o.sp_zero   = (sp_q == '0);
    stat_o.seen      = visited_q[stk_rd_q];
    stat_o.pend_vld  = pend_vld_q;
    stat_o.scan_done = (scan_q == '0);
    stat_o.out_free  = !out_vld_q || out_ready_i;
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign visited_label_o = label_q;
  assign is_last_o       = last_q;

endmodule

>>> design/adjacency_matrix_dfs_engine_top.sv
// Top level of the adjacency matrix depth-first search engine.
//
//   channel | direction | handshake             | payload
//   in      | request   | in_valid_i/in_ready_o | kind, vertex/source/dest labels, distance, start
//   out     | result    | out_valid_o/out_ready_i | status, visited_label, is_last
//
// After reset the edge matrix is swept to zero; no request is taken until the sweep is done.
// Insert edge: the labels of the V stored vertices are read in turn through the label table port.
// Search: each stack pop checks a visited mark; each visited vertex reads its matrix row entry by entry.
// One request at a time; a stalled result holds the engine only when a further result must follow.
module adjacency_matrix_dfs_engine_top #(
  parameter int MAX_VERTICES = 8,
  parameter int STACK_DEPTH  = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [amdfs_pkg::KindW-1:0]  kind_i,
  input  logic [amdfs_pkg::LabelW-1:0] vertex_value_i,
  input  logic [amdfs_pkg::LabelW-1:0] source_value_i,
  input  logic [amdfs_pkg::LabelW-1:0] dest_value_i,
  input  logic [amdfs_pkg::LabelW-1:0] edge_distance_i,
  input  logic [amdfs_pkg::StartW-1:0] start_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [amdfs_pkg::LabelW-1:0] visited_label_o,
  output logic                         is_last_o
);

  amdfs_pkg::cmd_t  cmd;
  amdfs_pkg::stat_t stat;

  amdfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  amdfs_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .kind_i          (kind_i),
    .vertex_value_i  (vertex_value_i),
    .source_value_i  (source_value_i),
    .dest_value_i    (dest_value_i),
    .edge_distance_i (edge_distance_i),
    .start_index_i   (start_index_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .visited_label_o (visited_label_o),
    .is_last_o       (is_last_o)
  );

endmodule

>>> design/amdfs_checker.sv
// Port-level assertions of the search engine, bound to the top level.
module amdfs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [amdfs_pkg::KindW-1:0]  kind_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   status_o,
  input logic [amdfs_pkg::LabelW-1:0] visited_label_o,
  input logic                         is_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(visited_label_o) && $stable(is_last_o))
    else $error("stalled result changed");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != amdfs_pkg::ST_OK |-> is_last_o && visited_label_o == '0)
    else $error("error result not final or carries a label");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_unused_kind_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == 2'd3 && !out_valid_o
      |=> !out_valid_o ##1 !out_valid_o)
    else $error("unused kind produced a result");

endmodule

bind adjacency_matrix_dfs_engine_top amdfs_checker u_amdfs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .kind_i          (kind_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .visited_label_o (visited_label_o),
  .is_last_o       (is_last_o)
);
